FILE: hw/rtl/crb_pkg.sv
// Package for the collision resolve and bounce core.
// Holds the stage record types, the divider step and saturation helpers.
// No dependencies.
`default_nettype none

package crb_pkg;

  // One quotient bit per divider stage; the bounce magnitude needs 33 bits.
  localparam int DivSteps = 33;
  localparam int RemW     = 80;
  localparam int NumW     = 113;
  localparam int NStg     = 5 + DivSteps + 1;

  localparam logic [16:0] EOne = 17'd65536;

  // Configuration register address.
  localparam logic RegRestitution = 1'b0;

  // Fields that ride along the pipeline unchanged.
  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] npos_x;
    logic signed [31:0] npos_y;
    logic               neg_x;
    logic               neg_y;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [63:0] prod_a;
    logic signed [63:0] prod_b;
    logic [63:0]        sq_x;
    logic [63:0]        sq_y;
    logic [31:0]        abs_px;
    logic [31:0]        abs_py;
    logic [17:0]        k;
  } s1_t;

  typedef struct packed {
    side_t              side;
    logic signed [64:0] dot;
    logic [63:0]        q;
    logic [48:0]        m_x;
    logic [48:0]        m_y;
  } s2_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] abs_d;
    logic [63:0] q;
    logic [48:0] m_x;
    logic [48:0] m_y;
    logic        bnc;
  } s3_t;

  // Partial products of |d| times the axis multiplier.
  typedef struct packed {
    logic [63:0] ll;
    logic [48:0] lh;
    logic [63:0] hl;
    logic [48:0] hh;
  } pp_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] q;
    pp_t         pp_x;
    pp_t         pp_y;
    logic        bnc;
  } s4_t;

  typedef struct packed {
    logic [RemW-1:0]     rem;
    logic [DivSteps-1:0] low;
    logic [DivSteps-1:0] quo;
  } axdiv_t;

  typedef struct packed {
    side_t           side;
    logic [RemW-1:0] dvs;
    axdiv_t          ax_x;
    axdiv_t          ax_y;
    logic            bnc;
  } div_t;

  // Sum of the partial products into the full numerator.
  function automatic logic [NumW-1:0] pp_sum(pp_t p);
    logic [NumW-1:0] s;
    s = NumW'(p.ll) + (NumW'(p.lh) << 32) + (NumW'(p.hl) << 32) + (NumW'(p.hh) << 64);
    return s;
  endfunction

  // Starting point of the restoring division.
  function automatic axdiv_t div_init(logic [NumW-1:0] n);
    axdiv_t a;
    a.rem = n[NumW-1:DivSteps];
    a.low = n[DivSteps-1:0];
    a.quo = '0;
    return a;
  endfunction

  // One restoring division step: shift in a numerator bit, try to subtract.
  function automatic axdiv_t div_step(axdiv_t a, logic [RemW-1:0] dv);
    axdiv_t      o;
    logic [RemW:0] r;
    logic        bitq;
    r    = {a.rem, a.low[DivSteps-1]};
    bitq = (r >= {1'b0, dv});
    if (bitq) begin
      r = r - {1'b0, dv};
    end
    o.rem = r[RemW-1:0];
    o.low = {a.low[DivSteps-2:0], 1'b0};
    o.quo = {a.quo[DivSteps-2:0], bitq};
    return o;
  endfunction

  // Saturate a 35-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/collision_resolve_bounce_core.sv
// The core has 39 register stages and accepts one contact per cycle while the output
// is not stalled; the depth is set by the 33-stage restoring divider, one quotient
// bit per stage, behind the multiplier stages. Each stage holds or advances on its
// own, so bubbles close up under output stall. Reset clears the valid bits and sets
// restitution to 1.0; payload registers are not reset.
// Depends on crb_pkg.
`default_nettype none

module collision_resolve_bounce_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] pen_x_i,
  input  wire logic signed [31:0] pen_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      new_pos_x_o,
  output logic signed [31:0]      new_pos_y_o,
  output logic signed [31:0]      new_vel_x_o,
  output logic signed [31:0]      new_vel_y_o,
  output logic                    bounced_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [0:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import crb_pkg::*;

  logic [16:0]     restitution_q;
  logic [NStg-1:0] vld_q, vld_d, adv;

  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  div_t div_q [DivSteps+1];
  div_t div0_d;

  logic signed [31:0] nvx_q, nvy_q, npx_q, npy_q;
  logic               bnc_q;
  logic signed [31:0] nvx_d, nvy_d;

  // Configuration port: single restitution register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[0] == RegRestitution) ? {15'd0, restitution_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= EOne;
    end else if (psel && penable && pwrite && pready && (paddr[0] == RegRestitution)) begin
      restitution_q <= pwdata[16:0];
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NStg; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage one: products, squares, absolute penetration and corrected position.
  always_comb begin
    logic signed [32:0] sx, sy;
    logic [16:0]        e;
    sx = 33'(pos_x_i) + 33'(pen_x_i);
    sy = 33'(pos_y_i) + 33'(pen_y_i);
    e  = (restitution_q > EOne) ? EOne : restitution_q;
    s1_d.side.vel_x  = vel_x_i;
    s1_d.side.vel_y  = vel_y_i;
    s1_d.side.npos_x = sat32(35'(sx));
    s1_d.side.npos_y = sat32(35'(sy));
    s1_d.side.neg_x  = pen_x_i[31];
    s1_d.side.neg_y  = pen_y_i[31];
    s1_d.prod_a      = 64'(vel_x_i) * 64'(pen_x_i);
    s1_d.prod_b      = 64'(vel_y_i) * 64'(pen_y_i);
    s1_d.sq_x        = 64'(64'(pen_x_i) * 64'(pen_x_i));
    s1_d.sq_y        = 64'(64'(pen_y_i) * 64'(pen_y_i));
    s1_d.abs_px      = pen_x_i[31] ? 32'(-pen_x_i) : 32'(pen_x_i);
    s1_d.abs_py      = pen_y_i[31] ? 32'(-pen_y_i) : 32'(pen_y_i);
    s1_d.k           = 18'(EOne) + 18'(e);
  end

  // Stage two: dot product, squared length and per-axis multipliers.
  always_comb begin
    logic [49:0] mx, my;
    mx = 50'(s1_q.abs_px) * 50'(s1_q.k);
    my = 50'(s1_q.abs_py) * 50'(s1_q.k);
    s2_d.side = s1_q.side;
    s2_d.dot  = $signed({s1_q.prod_a[63], s1_q.prod_a}) +
                $signed({s1_q.prod_b[63], s1_q.prod_b});
    s2_d.q    = s1_q.sq_x + s1_q.sq_y;
    s2_d.m_x  = mx[48:0];
    s2_d.m_y  = my[48:0];
  end

  // Stage three: decide the bounce and take the magnitude of the dot product.
  always_comb begin
    logic [64:0] nd;
    nd = 65'(-s2_q.dot);
    s3_d.side  = s2_q.side;
    s3_d.abs_d = nd[63:0];
    s3_d.q     = s2_q.q;
    s3_d.m_x   = s2_q.m_x;
    s3_d.m_y   = s2_q.m_y;
    s3_d.bnc   = (s2_q.q != 64'd0) && s2_q.dot[64];
  end

  // Stage four: partial products of the wide numerator.
  always_comb begin
    s4_d.side    = s3_q.side;
    s4_d.q       = s3_q.q;
    s4_d.bnc     = s3_q.bnc;
    s4_d.pp_x.ll = 64'(s3_q.abs_d[31:0]) * 64'(s3_q.m_x[31:0]);
    s4_d.pp_x.lh = 49'(s3_q.abs_d[31:0]) * 49'(s3_q.m_x[48:32]);
    s4_d.pp_x.hl = 64'(s3_q.abs_d[63:32]) * 64'(s3_q.m_x[31:0]);
    s4_d.pp_x.hh = 49'(s3_q.abs_d[63:32]) * 49'(s3_q.m_x[48:32]);
    s4_d.pp_y.ll = 64'(s3_q.abs_d[31:0]) * 64'(s3_q.m_y[31:0]);
    s4_d.pp_y.lh = 49'(s3_q.abs_d[31:0]) * 49'(s3_q.m_y[48:32]);
    s4_d.pp_y.hl = 64'(s3_q.abs_d[63:32]) * 64'(s3_q.m_y[31:0]);
    s4_d.pp_y.hh = 49'(s3_q.abs_d[63:32]) * 49'(s3_q.m_y[48:32]);
  end

  // Stage five: numerator sum and divider set-up; divisor is q scaled by 2^16.
  always_comb begin
    div0_d.side = s4_q.side;
    div0_d.bnc  = s4_q.bnc;
    div0_d.dvs  = {s4_q.q, 16'd0};
    div0_d.ax_x = div_init(pp_sum(s4_q.pp_x));
    div0_d.ax_y = div_init(pp_sum(s4_q.pp_y));
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) s4_q <= s4_d;
  end

  // Divider set-up register and divider stages, one quotient bit each.
  always_ff @(posedge clk_i) begin
    if (adv[4]) div_q[0] <= div0_d;
    for (int j = 1; j <= DivSteps; j++) begin
      if (adv[4+j]) begin
        div_q[j].side <= div_q[j-1].side;
        div_q[j].bnc  <= div_q[j-1].bnc;
        div_q[j].dvs  <= div_q[j-1].dvs;
        div_q[j].ax_x <= div_step(div_q[j-1].ax_x, div_q[j-1].dvs);
        div_q[j].ax_y <= div_step(div_q[j-1].ax_y, div_q[j-1].dvs);
      end
    end
  end

  // Final stage: apply the correction with the sign of the normal, saturate.
  always_comb begin
    logic signed [34:0] vx, vy, mx, my;
    vx = 35'(div_q[DivSteps].side.vel_x);
    vy = 35'(div_q[DivSteps].side.vel_y);
    mx = $signed({2'b00, div_q[DivSteps].ax_x.quo});
    my = $signed({2'b00, div_q[DivSteps].ax_y.quo});
    if (div_q[DivSteps].bnc) begin
      nvx_d = sat32(div_q[DivSteps].side.neg_x ? vx - mx : vx + mx);
      nvy_d = sat32(div_q[DivSteps].side.neg_y ? vy - my : vy + my);
    end else begin
      nvx_d = div_q[DivSteps].side.vel_x;
      nvy_d = div_q[DivSteps].side.vel_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NStg-1]) begin
      nvx_q <= nvx_d;
      nvy_q <= nvy_d;
      npx_q <= div_q[DivSteps].side.npos_x;
      npy_q <= div_q[DivSteps].side.npos_y;
      bnc_q <= div_q[DivSteps].bnc;
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign new_pos_x_o = npx_q;
  assign new_pos_y_o = npy_q;
  assign new_vel_x_o = nvx_q;
  assign new_vel_y_o = nvy_q;
  assign bounced_o   = bnc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/crb_checker.sv
// Port-level checks for the collision resolve and bounce core.
// Bound to collision_resolve_bounce_core; uses no package.
`default_nettype none

module crb_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] new_vel_x_o,
  input wire logic        bounced_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [0:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_vel_x_o) && $stable(bounced_o))
    else $error("held result changed");

  // The input only stalls when the whole pipeline is full and blocked.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A register write is read back.
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 1'b0 |=>
      paddr != 1'b0 || prdata[16:0] == $past(pwdata[16:0]))
    else $error("restitution read-back mismatch");

  // Unused read bits stay zero.
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:17] == 15'd0)
    else $error("nonzero upper read bits");

endmodule

bind collision_resolve_bounce_core crb_assert u_crb_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .new_vel_x_o (new_vel_x_o),
  .bounced_o   (bounced_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire

FILE: dv/crb_checker.sv
// Checker for the collision resolve and bounce core: snoops both channels and
// the register port, predicts each contact's result and compares it.
// Does not depend on crb_pkg; no RTL functions are used.
`timescale 1ns / 100ps

module crb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] pen_x_i,
  input  logic signed [31:0] pen_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] new_pos_x_i,
  input  logic signed [31:0] new_pos_y_i,
  input  logic signed [31:0] new_vel_x_i,
  input  logic signed [31:0] new_vel_y_i,
  input  logic               bounced_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [0:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               bnc;
  } contact_res_t;

  contact_res_t resolved_q[$];
  logic [16:0]  restitution_q;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Velocity correction along one axis, applied with the sign of the normal.
  function automatic logic signed [31:0] bounce_axis(logic signed [63:0] v,
      logic signed [63:0] p, logic [63:0] abs_d, logic [63:0] q, logic [17:0] k);
    logic [63:0]  abs_p;
    logic [129:0] num;
    logic [129:0] quo;
    logic [63:0]  mag;
    abs_p = p < 0 ? -p : p;
    num   = 130'(abs_d) * 130'(abs_p) * 130'(k);
    quo   = num / 130'(q);
    mag   = quo[63:0] >> 16;
    if (p < 0) return clamp32(66'(v) - $signed({2'b00, mag}));
    return clamp32(66'(v) + $signed({2'b00, mag}));
  endfunction

  function automatic contact_res_t resolve_contact(logic signed [63:0] px0,
      logic signed [63:0] py0, logic signed [63:0] vx, logic signed [63:0] vy,
      logic signed [63:0] px, logic signed [63:0] py, logic [16:0] e_reg);
    contact_res_t       r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [64:0] d;
    logic [63:0]        q;
    logic [63:0]        abs_d;
    logic [17:0]        k;
    a = vx * px;
    b = vy * py;
    q = px * px + py * py;
    k = 18'd65536 + ((e_reg > 17'd65536) ? 18'd65536 : 18'(e_reg));
    r.pos_x = clamp32(66'(px0) + 66'(px));
    r.pos_y = clamp32(66'(py0) + 66'(py));
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    r.bnc   = 1'b0;
    // Only an approaching body with a nonzero normal is reflected.
    if (q != 0 && !(a >= 0 && b >= 0)) begin
      d = 65'(a) + 65'(b);
      if (d < 0) begin
        abs_d   = 64'(-d);
        r.vel_x = bounce_axis(vx, px, abs_d, q, k);
        r.vel_y = bounce_axis(vy, py, abs_d, q, k);
        r.bnc   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = resolved_q.size();

  // Register writes, input transactions and output transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t want;
    if (!rst_ni) begin
      restitution_q = 17'd65536;
      resolved_q.delete();
      fail_count_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 1'b0) begin
        restitution_q = pwdata_i[16:0];
      end
      if (in_valid_i && !in_stall_i) begin
        resolved_q.push_back(resolve_contact(pos_x_i, pos_y_i, vel_x_i, vel_y_i,
                                             pen_x_i, pen_y_i, restitution_q));
      end
      if (out_valid_i && !out_stall_i) begin
        if (resolved_q.size() == 0) begin
          report_mismatch("unexpected result", new_pos_x_i, 32'h0);
        end else begin
          want = resolved_q.pop_front();
          if (new_pos_x_i !== want.pos_x) report_mismatch("new_pos_x", new_pos_x_i, want.pos_x);
          if (new_pos_y_i !== want.pos_y) report_mismatch("new_pos_y", new_pos_y_i, want.pos_y);
          if (new_vel_x_i !== want.vel_x) report_mismatch("new_vel_x", new_vel_x_i, want.vel_x);
          if (new_vel_y_i !== want.vel_y) report_mismatch("new_vel_y", new_vel_y_i, want.vel_y);
          if (bounced_i !== want.bnc) report_mismatch("bounced", 32'(bounced_i), 32'(want.bnc));
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the collision resolve and bounce core: clock, reset,
// contact stimulus, output stall and register writes. Depends on crb_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int Latency = 39;
  localparam int CycleLimit = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic signed [31:0] pen_x_i = '0, pen_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;
  logic               bounced_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 stall_mode = 0;

  collision_resolve_bounce_core i_dut (.*);

  crb_checker i_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i, .pen_x_i, .pen_y_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .new_pos_x_i(new_pos_x_o), .new_pos_y_i(new_pos_y_o),
    .new_vel_x_i(new_vel_x_o), .new_vel_y_i(new_vel_y_o), .bounced_i(bounced_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output stall: the pattern changes at random between none, random and periodic.
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ($urandom_range(0, 99) < 75);
      default: out_stall_i <= ((cycles / 7) % 3 == 0);
    endcase
  end

  task automatic write_restitution(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait for every expected result, then for the pipeline to drain.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic send_contact(logic [31:0] px0, logic [31:0] py0, logic [31:0] vx,
                              logic [31:0] vy, logic [31:0] px, logic [31:0] py);
    @(negedge clk_i);
    pos_x_i <= px0; pos_y_i <= py0; vel_x_i <= vx; vel_y_i <= vy;
    pen_x_i <= px; pen_y_i <= py; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly modest Q16.16 magnitudes, with full-range and edge values mixed in.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
    if (sel < 8) return $urandom;
    if (sel == 8) return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
    return 32'($signed($urandom_range(0, 6)) - 3);
  endfunction

  task automatic send_directed();
    send_contact(32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0, 32'h7fffffff, 32'h80000000);
    send_contact(32'h80000000, 32'h7fffffff, 32'hffff0000, 32'h0, 32'h80000000, 32'h7fffffff);
    // Zero penetration.
    send_contact(32'h00050000, 32'h00020000, 32'hfff00000, 32'h00030000, 32'h0, 32'h0);
    // Moving away from the contact.
    send_contact(32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00000100, 32'h00000100);
    // Sliding along the surface: zero dot product.
    send_contact(32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00001000);
    // Head-on approaches along each axis and diagonally.
    send_contact(32'h00100000, 32'h0, 32'hfffe0000, 32'h0, 32'h00000800, 32'h0);
    send_contact(32'h0, 32'h00100000, 32'h0, 32'h00030000, 32'h0, 32'hfffff000);
    send_contact(32'h1, 32'h2, 32'hffff0000, 32'hffff0000, 32'h00000400, 32'h00000400);
    // Mixed signs in the products with a negative sum.
    send_contact(32'h0, 32'h0, 32'h00050000, 32'hfff00000, 32'h00010000, 32'h00020000);
    // Extreme velocities and normals.
    send_contact(32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_contact(32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_contact(32'h0, 32'h0, 32'h80000000, 32'h7fffffff, 32'h1, 32'h0);
    send_contact(32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    send_contact(32'hffffffff, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h80000000);
  endtask

  task automatic send_random(int count);
    int burst;
    int vx;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        vx = pick_value();
        send_contact(pick_value(), pick_value(), vx, pick_value(),
                     pick_value(), pick_value());
        count--;
      end
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [31:0] settings[5];
    settings = '{32'd65536, 32'd0, 32'h1ffff, 32'd32768, 32'd0};
    settings[4] = $urandom_range(0, 131071);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_directed();
    send_random(150);
    foreach (settings[i]) begin
      wait_idle();
      write_restitution(settings[i]);
      if (i == 1) send_directed();
      send_random(220);
    end
    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
